@@ hw/rtl/cxps_pkg.sv @@
// ----------------------------------------------------------------------------
// cxps_pkg
// Shared types and constants for the circular cross-correlation peak search.
// ----------------------------------------------------------------------------
package cxps_pkg;

  // vector geometry
  localparam int BINS    = 12;
  localparam int IDX_W   = $clog2(BINS);
  localparam int LEVEL_W = 16;
  localparam int SHIFT_W = 6;

  // arithmetic widths
  localparam int ENERGY_W   = 40;
  localparam int ROOT_SHIFT = 24;
  localparam int ROOT_IN_W  = ENERGY_W + ROOT_SHIFT;
  localparam int ROOT_W     = ROOT_IN_W / 2;
  localparam int PROD_W     = 2 * ROOT_W;
  localparam int DIV_BITS   = 40;
  localparam int CNT_W      = $clog2(DIV_BITS);
  localparam int SCORE_W    = 17;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SEARCH_ALL = 1'b0;

  typedef struct packed {
    logic [LEVEL_W-1:0] this_level;
    logic [LEVEL_W-1:0] that_level;
    logic               last_bin;
    logic               this_is_end;
    logic               that_is_end;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [SHIFT_W-1:0] best_shift;
    logic               zero_energy;
  } out_t;

endpackage

@@ hw/rtl/circular_xcorr_peak_search_top.sv @@
// ----------------------------------------------------------------------------
// circular_xcorr_peak_search_top
// Loads two chroma vectors bin by bin, finds the best circular correlation
// shift and reports the score normalized by the vector roots.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start / busy         in_data  (in_t)
//  result    out_valid strobe     out_data (out_t)
//  config    APB psel/penable     paddr, pwdata, prdata
//
//  A bin without last_bin is only stored and leaves the block idle. A last
//  bin starts a run through one shared multiplier: (2 + shifts) passes over
//  the vector RAMs, 2 * ROOT_W root steps, one root product, one range check
//  and DIV_BITS divide steps; a zero energy ends the run after the passes and
//  the range check can end it before the divide. End markers report without a run.
//  Reset clears control state only. The result strobe lasts one cycle and
//  cannot be stalled.
// ----------------------------------------------------------------------------
module circular_xcorr_peak_search_top
  import cxps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  output logic               out_valid,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PASS = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DCHK = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;

  localparam logic [1:0] KIND_EA   = 2'd0;
  localparam logic [1:0] KIND_EB   = 2'd1;
  localparam logic [1:0] KIND_CORR = 2'd2;

  localparam int SQ_REM_W = ROOT_W + 4;

  logic [2:0]          state_r;
  logic [1:0]          kind_r;
  logic                search_r;
  logic [IDX_W-1:0]    load_r;
  logic [IDX_W-1:0]    j_r;
  logic [IDX_W-1:0]    k_r;
  logic [IDX_W-1:0]    shift_r;
  logic [IDX_W-1:0]    best_shift_r;
  logic                iss_r;
  logic                v1_r;
  logic                l1_r;
  logic                v2_r;
  logic                l2_r;
  logic [PROD_W-1:0]   mul_r;
  logic [ENERGY_W-1:0] acc_r;
  logic [ENERGY_W-1:0] ea_r;
  logic [ENERGY_W-1:0] eb_r;
  logic [ENERGY_W-1:0] best_r;
  logic [ROOT_IN_W-1:0] src_r;
  logic [SQ_REM_W-1:0] sq_rem_r;
  logic [ROOT_W-1:0]   sq_q_r;
  logic                root_sel_r;
  logic [ROOT_W-1:0]   ra_r;
  logic [ROOT_W-1:0]   rb_r;
  logic [PROD_W-1:0]   dv_rem_r;
  logic [DIV_BITS-1:0] dv_q_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  out_t                out_r;

  logic                accept;
  logic                cfg_write;
  logic [LEVEL_W-1:0]  rd_a;
  logic [LEVEL_W-1:0]  rd_b;
  logic [ROOT_W-1:0]   mul_x;
  logic [ROOT_W-1:0]   mul_y;
  logic [PROD_W-1:0]   mul_p;
  logic [ENERGY_W-1:0] total;
  logic                last_shift;
  logic [SQ_REM_W-1:0] sq_sh;
  logic [SQ_REM_W-1:0] sq_trial;
  logic                sq_ge;
  logic [SQ_REM_W-1:0] sq_rem_nxt;
  logic [ROOT_W-1:0]   sq_q_nxt;
  logic [PROD_W:0]     dv_sh;
  logic [PROD_W:0]     dv_diff;
  logic                dv_ge;
  logic [PROD_W-1:0]   dv_rem_nxt;
  logic [DIV_BITS-1:0] dv_q_nxt;
  logic [SCORE_W-1:0]  dv_score;
  logic [IDX_W-1:0]    load_nxt;
  logic [IDX_W-1:0]    k_nxt;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_SEARCH_ALL) ? PDATA_W'(search_r) : '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // vector stores
  cxps_ram #(.WIDTH(LEVEL_W), .DEPTH(BINS)) u_ram_a (
    .clk   (clk),
    .we    (accept),
    .waddr (load_r),
    .wdata (in_data.this_level),
    .raddr (j_r),
    .rdata (rd_a)
  );

  cxps_ram #(.WIDTH(LEVEL_W), .DEPTH(BINS)) u_ram_b (
    .clk   (clk),
    .we    (accept),
    .waddr (load_r),
    .wdata (in_data.that_level),
    .raddr (k_r),
    .rdata (rd_b)
  );

  // route operands into the shared multiplier
  always_comb begin
    if (state_r == ST_MUL) begin
      mul_x = ra_r;
      mul_y = rb_r;
    end else begin
      mul_x = ROOT_W'((kind_r == KIND_EB) ? rd_b : rd_a);
      mul_y = ROOT_W'((kind_r == KIND_EA) ? rd_a : rd_b);
    end
    mul_p = mul_x * mul_y;
  end

  // pass sum and slot counters
  assign total      = acc_r + mul_r[ENERGY_W-1:0];
  assign last_shift = !search_r || (shift_r == IDX_W'(BINS - 1));
  assign load_nxt   = (load_r == IDX_W'(BINS - 1)) ? '0 : load_r + 1'b1;
  assign k_nxt      = (k_r == IDX_W'(BINS - 1)) ? '0 : k_r + 1'b1;

  // one root digit per step
  always_comb begin
    sq_sh      = {sq_rem_r[SQ_REM_W-3:0], src_r[ROOT_IN_W-1 -: 2]};
    sq_trial   = {2'b00, sq_q_r, 2'b01};
    sq_ge      = (sq_sh >= sq_trial);
    sq_rem_nxt = sq_ge ? (sq_sh - sq_trial) : sq_sh;
    sq_q_nxt   = {sq_q_r[ROOT_W-2:0], sq_ge};
  end

  // one quotient bit per step, divisor held in mul_r
  always_comb begin
    dv_sh      = {dv_rem_r, 1'b0};
    dv_diff    = dv_sh - {1'b0, mul_r};
    dv_ge      = (dv_sh >= {1'b0, mul_r});
    dv_rem_nxt = dv_ge ? dv_diff[PROD_W-1:0] : dv_sh[PROD_W-1:0];
    dv_q_nxt   = {dv_q_r[DIV_BITS-2:0], dv_ge};
    dv_score   = (dv_q_nxt > DIV_BITS'(SCORE_ONE)) ? SCORE_ONE : dv_q_nxt[SCORE_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      search_r    <= 1'b1;
      load_r      <= '0;
      iss_r       <= 1'b0;
      v1_r        <= 1'b0;
      l1_r        <= 1'b0;
      v2_r        <= 1'b0;
      l2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      // take a register write
      if (cfg_write && (paddr[2] == REG_SEARCH_ALL)) begin
        search_r <= pwdata[0];
      end

      // multiply-accumulate pipeline
      v1_r <= iss_r;
      l1_r <= iss_r && (j_r == IDX_W'(BINS - 1));
      v2_r <= v1_r;
      l2_r <= l1_r;
      if (v1_r || (state_r == ST_MUL)) begin
        mul_r <= mul_p;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            load_r <= in_data.last_bin ? '0 : load_nxt;
            if (in_data.last_bin) begin
              if (in_data.this_is_end || in_data.that_is_end) begin
                out_valid_r          <= 1'b1;
                out_r.score          <= (in_data.this_is_end && in_data.that_is_end) ?
                                        SCORE_ONE : '0;
                out_r.best_shift     <= '0;
                out_r.zero_energy    <= 1'b0;
              end else begin
                state_r      <= ST_PASS;
                kind_r       <= KIND_EA;
                j_r          <= '0;
                k_r          <= '0;
                iss_r        <= 1'b1;
                acc_r        <= '0;
                shift_r      <= '0;
                best_r       <= '0;
                best_shift_r <= '0;
              end
            end
          end
        end

        ST_PASS: begin
          // issue reads
          if (iss_r) begin
            j_r <= j_r + 1'b1;
            k_r <= k_nxt;
            if (j_r == IDX_W'(BINS - 1)) begin
              iss_r <= 1'b0;
            end
          end
          // accumulate, close the pass on its last product
          if (v2_r) begin
            acc_r <= total;
          end
          if (l2_r) begin
            acc_r <= '0;
            j_r   <= '0;
            iss_r <= 1'b1;
            case (kind_r)
              KIND_EA: begin
                ea_r   <= total;
                kind_r <= KIND_EB;
                k_r    <= '0;
              end
              KIND_EB: begin
                eb_r    <= total;
                kind_r  <= KIND_CORR;
                k_r     <= '0;
                shift_r <= '0;
              end
              default: begin
                if (total > best_r) begin
                  best_r       <= total;
                  best_shift_r <= shift_r;
                end
                if (last_shift) begin
                  iss_r <= 1'b0;
                  if ((ea_r == '0) || (eb_r == '0)) begin
                    state_r           <= ST_IDLE;
                    out_valid_r       <= 1'b1;
                    out_r.score       <= '0;
                    out_r.best_shift  <= '0;
                    out_r.zero_energy <= 1'b1;
                  end else begin
                    state_r    <= ST_SQRT;
                    src_r      <= {ea_r, ROOT_SHIFT'(0)};
                    sq_rem_r   <= '0;
                    sq_q_r     <= '0;
                    root_sel_r <= 1'b0;
                    cnt_r      <= '0;
                  end
                end else begin
                  shift_r <= shift_r + 1'b1;
                  k_r     <= shift_r + 1'b1;
                end
              end
            endcase
          end
        end

        ST_SQRT: begin
          src_r    <= src_r << 2;
          sq_rem_r <= sq_rem_nxt;
          sq_q_r   <= sq_q_nxt;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            cnt_r    <= '0;
            sq_rem_r <= '0;
            sq_q_r   <= '0;
            if (!root_sel_r) begin
              ra_r       <= sq_q_nxt;
              src_r      <= {eb_r, ROOT_SHIFT'(0)};
              root_sel_r <= 1'b1;
            end else begin
              rb_r    <= sq_q_nxt;
              state_r <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          state_r <= ST_DCHK;
        end

        ST_DCHK: begin
          out_r.best_shift  <= SHIFT_W'(best_shift_r);
          out_r.zero_energy <= 1'b0;
          if (PROD_W'(best_r) >= mul_r) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_r.score <= SCORE_ONE;
          end else begin
            state_r  <= ST_DIV;
            dv_rem_r <= PROD_W'(best_r);
            dv_q_r   <= '0;
            cnt_r    <= '0;
          end
        end

        ST_DIV: begin
          dv_rem_r <= dv_rem_nxt;
          dv_q_r   <= dv_q_nxt;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_r.score <= dv_score;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/cxps_ram.sv @@
// ----------------------------------------------------------------------------
// cxps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cxps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
